[hdl/cas_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cas_pkg: shared types and constants of the clamp alignment sequencer
// Beat structs for both channels, step codes, register indexes and the
// reset values of the delay registers.
// ----------------------------------------------------------------------------
package cas_pkg;

  // Width of one delay register and of the register index on the write port
  localparam int unsigned DelayW    = 16;
  localparam int unsigned CfgIndexW = 8;

  // Register indexes
  localparam logic [CfgIndexW-1:0] RegPreExtend   = 8'd0;
  localparam logic [CfgIndexW-1:0] RegExtendHold  = 8'd1;
  localparam logic [CfgIndexW-1:0] RegAfterRetract = 8'd2;
  localparam logic [CfgIndexW-1:0] RegClampSettle = 8'd3;

  // Register reset values
  localparam logic [DelayW-1:0] PreExtendRst    = 16'd500;
  localparam logic [DelayW-1:0] ExtendHoldRst   = 16'd500;
  localparam logic [DelayW-1:0] AfterRetractRst = 16'd200;
  localparam logic [DelayW-1:0] ClampSettleRst  = 16'd200;

  // Sequence step codes
  localparam logic [3:0] StepNudge      = 4'd0;
  localparam logic [3:0] StepMotorWait  = 4'd1;
  localparam logic [3:0] StepAlignExt   = 4'd2;
  localparam logic [3:0] StepPreDwell   = 4'd3;
  localparam logic [3:0] StepLeftClamp  = 4'd4;
  localparam logic [3:0] StepHoldDwell  = 4'd5;
  localparam logic [3:0] StepAlignRet   = 4'd6;
  localparam logic [3:0] StepRetDwell   = 4'd7;
  localparam logic [3:0] StepRightClamp = 4'd8;
  localparam logic [3:0] StepSettle     = 4'd9;

  // One input beat: one tick
  typedef struct packed {
    logic start_pressed;
    logic motor_busy;
  } in_beat_t;

  // One result beat
  typedef struct packed {
    logic [3:0] step_now;
    logic       motor_nudge;
    logic       align_extend;
    logic       align_retract;
    logic       left_clamp_on;
    logic       right_clamp_on;
    logic       sequence_done;
    logic       aborted;
  } out_beat_t;

  // Dwell delays handed from the register file to the step logic
  typedef struct packed {
    logic [DelayW-1:0] pre_extend;
    logic [DelayW-1:0] extend_hold;
    logic [DelayW-1:0] after_retract;
    logic [DelayW-1:0] clamp_settle;
  } delays_t;

endpackage

[hdl/cas_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cas_cfg_regs: delay register file
// Four 16-bit dwell delays, written one per beat; indexes past the last
// register are dropped.
// ----------------------------------------------------------------------------
module cas_cfg_regs import cas_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [DelayW-1:0]    cfg_data_i,
  output delays_t              delays_o
);

  delays_t delays_q;

  // Always take a write
  assign cfg_ready_o = 1'b1;
  assign delays_o    = delays_q;

  // Update the addressed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delays_q.pre_extend    <= PreExtendRst;
      delays_q.extend_hold   <= ExtendHoldRst;
      delays_q.after_retract <= AfterRetractRst;
      delays_q.clamp_settle  <= ClampSettleRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegPreExtend:    delays_q.pre_extend    <= cfg_data_i;
        RegExtendHold:   delays_q.extend_hold   <= cfg_data_i;
        RegAfterRetract: delays_q.after_retract <= cfg_data_i;
        RegClampSettle:  delays_q.clamp_settle  <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

[hdl/cas_step_logic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cas_step_logic: sequence step and dwell timer
// Holds the step and the saturating tick counter and works out one tick:
// next step, next count and the result beat.
// ----------------------------------------------------------------------------
module cas_step_logic import cas_pkg::*; #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  in_beat_t  tick_i,
  input  delays_t   delays_i,
  output out_beat_t result_o
);

  localparam int unsigned CmpW = (TIMER_WIDTH > DelayW) ? TIMER_WIDTH : DelayW;
  localparam logic [TIMER_WIDTH-1:0] TimerMax = {TIMER_WIDTH{1'b1}};

  logic [3:0]             step_q, step_d;
  logic [TIMER_WIDTH-1:0] timer_q, timer_d;
  logic [TIMER_WIDTH-1:0] timer_inc;
  logic [DelayW-1:0]      dwell_delay;
  logic                   dwell_over;

  // Count the tick, saturating
  assign timer_inc = (timer_q == TimerMax) ? timer_q : timer_q + 1'b1;

  // Pick the delay of the current dwell
  always_comb begin
    unique case (step_q)
      StepPreDwell:  dwell_delay = delays_i.pre_extend;
      StepHoldDwell: dwell_delay = delays_i.extend_hold;
      StepRetDwell:  dwell_delay = delays_i.after_retract;
      default:       dwell_delay = delays_i.clamp_settle;
    endcase
  end

  assign dwell_over = CmpW'(timer_inc) >= CmpW'(dwell_delay);

  // Work out the next step and the pulses
  always_comb begin
    step_d   = step_q;
    timer_d  = timer_q;
    result_o = '0;
    if (tick_i.start_pressed) begin
      step_d           = StepNudge;
      timer_d          = '0;
      result_o.aborted = 1'b1;
    end else begin
      unique case (step_q)
        StepNudge: begin
          result_o.motor_nudge = 1'b1;
          step_d  = StepMotorWait;
          timer_d = '0;
        end
        StepMotorWait: begin
          if (!tick_i.motor_busy) begin
            step_d  = StepAlignExt;
            timer_d = '0;
          end
        end
        StepAlignExt: begin
          result_o.align_extend = 1'b1;
          step_d  = StepPreDwell;
          timer_d = '0;
        end
        StepLeftClamp: begin
          result_o.left_clamp_on = 1'b1;
          step_d  = StepHoldDwell;
          timer_d = '0;
        end
        StepAlignRet: begin
          result_o.align_retract = 1'b1;
          step_d  = StepRetDwell;
          timer_d = '0;
        end
        StepRightClamp: begin
          result_o.right_clamp_on = 1'b1;
          step_d  = StepSettle;
          timer_d = '0;
        end
        StepPreDwell, StepHoldDwell, StepRetDwell: begin
          timer_d = timer_inc;
          if (dwell_over) begin
            step_d  = step_q + 4'd1;
            timer_d = '0;
          end
        end
        StepSettle: begin
          timer_d = timer_inc;
          if (dwell_over) begin
            result_o.sequence_done = 1'b1;
            step_d  = StepNudge;
            timer_d = '0;
          end
        end
        default: begin
          // Unused code: fall back to the start of the sequence
          step_d  = StepNudge;
          timer_d = '0;
        end
      endcase
    end
    result_o.step_now = step_d;
  end

  // Advance the state on each processed tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= StepNudge;
      timer_q <= '0;
    end else if (en_i) begin
      step_q  <= step_d;
      timer_q <= timer_d;
    end
  end

  // A start press always lands on step 0 with a clear timer
  a_abort_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && tick_i.start_pressed |=> step_q == StepNudge && timer_q == '0)
    else $error("abort did not clear step and timer");

  // State holds between ticks
  a_hold_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(step_q) && $stable(timer_q))
    else $error("state moved without a tick");

  // The timer only runs inside a dwell step
  a_timer_dwell : assert property (@(posedge clk_i) disable iff (!rst_ni)
    timer_q != '0 |-> step_q == StepPreDwell || step_q == StepHoldDwell ||
                      step_q == StepRetDwell || step_q == StepSettle)
    else $error("timer running outside a dwell");

endmodule

[hdl/clamp_alignment_sequencer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clamp_alignment_sequencer_unit: clamp alignment sequencer top level
// Input register, step logic, result register and the delay register file.
// ----------------------------------------------------------------------------
// Each input beat is one millisecond tick and yields exactly one result beat.
// A beat is captured in an input register; the step and dwell timer are
// updated as the result is loaded into the output register, which waits
// while a stalled result is still held there. One beat is taken every cycle
// while the output side keeps up; the output register and the input register
// together absorb a stall without losing a beat. Delay registers are to be
// written through the config port only while no tick is in flight; the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
module clamp_alignment_sequencer_unit import cas_pkg::*; #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_beat_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_beat_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [DelayW-1:0]    cfg_data_i
);

  logic      in_valid_q;
  in_beat_t  in_data_q;
  logic      out_valid_q;
  out_beat_t out_data_q;
  out_beat_t result;
  delays_t   delays;
  logic      out_free;
  logic      advance;

  cas_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .delays_o    (delays)
  );

  cas_step_logic #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .tick_i   (in_data_q),
    .delays_i (delays),
    .result_o (result)
  );

  // Move a beat forward when the result register is free or being emptied
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  // Capture an accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_data_q <= in_data_i;
    end
  end

  // Load the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[tb/cas_tick_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cas_tick_checker: result checker for the clamp alignment sequencer
// Watches the tick, result and register write channels, runs its own copy of
// the step sequence and dwell timer, and compares every result beat in order
// against the predicted one.
// ----------------------------------------------------------------------------
module cas_tick_checker import cas_pkg::*; #(
  parameter int unsigned TimerW = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  in_beat_t             in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  out_beat_t            out_data_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [DelayW-1:0]    cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   done_count_o,
  output int                   abort_count_o
);

  // Shadow copy of the delay registers
  logic [DelayW-1:0] pre_extend_q;
  logic [DelayW-1:0] extend_hold_q;
  logic [DelayW-1:0] after_retract_q;
  logic [DelayW-1:0] clamp_settle_q;

  // Shadow copy of the sequencer state
  logic [3:0]        step_q;
  logic [TimerW-1:0] elapsed_q;

  out_beat_t result_queue[$];
  out_beat_t want;

  // Change step and restart the dwell timer
  function automatic void move_to(logic [3:0] next_step);
    step_q    = next_step;
    elapsed_q = '0;
  endfunction

  // Count one dwell tick, saturating; true once the delay is reached
  function automatic logic dwell_over(logic [DelayW-1:0] limit);
    if (elapsed_q != '1) elapsed_q = elapsed_q + 1'b1;
    return elapsed_q >= limit;
  endfunction

  // Advance the sequence by one tick and build the result it produces
  function automatic out_beat_t tick_result(in_beat_t tick);
    out_beat_t res;
    res = '0;
    if (tick.start_pressed) begin
      res.aborted = 1'b1;
      move_to(StepNudge);
    end else begin
      case (step_q)
        StepNudge: begin
          res.motor_nudge = 1'b1;
          move_to(StepMotorWait);
        end
        StepMotorWait: begin
          if (!tick.motor_busy) move_to(StepAlignExt);
        end
        StepAlignExt: begin
          res.align_extend = 1'b1;
          move_to(StepPreDwell);
        end
        StepPreDwell: begin
          if (dwell_over(pre_extend_q)) move_to(StepLeftClamp);
        end
        StepLeftClamp: begin
          res.left_clamp_on = 1'b1;
          move_to(StepHoldDwell);
        end
        StepHoldDwell: begin
          if (dwell_over(extend_hold_q)) move_to(StepAlignRet);
        end
        StepAlignRet: begin
          res.align_retract = 1'b1;
          move_to(StepRetDwell);
        end
        StepRetDwell: begin
          if (dwell_over(after_retract_q)) move_to(StepRightClamp);
        end
        StepRightClamp: begin
          res.right_clamp_on = 1'b1;
          move_to(StepSettle);
        end
        StepSettle: begin
          if (dwell_over(clamp_settle_q)) begin
            res.sequence_done = 1'b1;
            move_to(StepNudge);
          end
        end
        default: begin
          move_to(StepNudge);
        end
      endcase
    end
    res.step_now = step_q;
    return res;
  endfunction

  task automatic compare_field(string name, int unsigned exp_val, int unsigned got_val);
    if (exp_val != got_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      fail_count_o++;
    end
  endtask

  // Track register writes, predict each accepted tick, check each result beat
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_extend_q    = PreExtendRst;
      extend_hold_q   = ExtendHoldRst;
      after_retract_q = AfterRetractRst;
      clamp_settle_q  = ClampSettleRst;
      step_q          = StepNudge;
      elapsed_q       = '0;
      result_queue.delete();
      pending_o       = 0;
      fail_count_o    = 0;
      done_count_o    = 0;
      abort_count_o   = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegPreExtend:    pre_extend_q    = cfg_data_i;
          RegExtendHold:   extend_hold_q   = cfg_data_i;
          RegAfterRetract: after_retract_q = cfg_data_i;
          RegClampSettle:  clamp_settle_q  = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) result_queue.push_back(tick_result(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (result_queue.size() == 0) begin
          $error("result beat with no tick outstanding (step_now %0d)",
                 out_data_i.step_now);
          fail_count_o++;
        end else begin
          want = result_queue.pop_front();
          compare_field("step_now", want.step_now, out_data_i.step_now);
          compare_field("motor_nudge", want.motor_nudge, out_data_i.motor_nudge);
          compare_field("align_extend", want.align_extend, out_data_i.align_extend);
          compare_field("align_retract", want.align_retract, out_data_i.align_retract);
          compare_field("left_clamp_on", want.left_clamp_on, out_data_i.left_clamp_on);
          compare_field("right_clamp_on", want.right_clamp_on, out_data_i.right_clamp_on);
          compare_field("sequence_done", want.sequence_done, out_data_i.sequence_done);
          compare_field("aborted", want.aborted, out_data_i.aborted);
          if (out_data_i.sequence_done === 1'b1) done_count_o++;
          if (out_data_i.aborted === 1'b1) abort_count_o++;
        end
      end
      pending_o = result_queue.size();
    end
  end

endmodule

[tb/clamp_alignment_sequencer_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clamp_alignment_sequencer_unit_tb: testbench of the clamp alignment sequencer
// Drives a directed run through every step, abort and short dwell, then
// random tick streams under several delay settings and idle patterns, and
// leaves all checking to the tick checker beside the block.
// ----------------------------------------------------------------------------
module clamp_alignment_sequencer_unit_tb import cas_pkg::*;;

  localparam int unsigned TimerW     = 16;
  localparam int          CycleLimit = 400000;
  localparam int          NumPhases  = 8;
  localparam int          HoldCycles = 60;

  // Delay setting styles used by the random phases
  localparam int DlyShort = 0;
  localparam int DlyZero  = 1;
  localparam int DlyMax   = 2;
  localparam int DlyWide  = 3;
  localparam int DlyMixed = 4;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  in_beat_t             in_data_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  out_beat_t            out_data_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i;
  logic [DelayW-1:0]    cfg_data_i;

  int fail_count;
  int pending;
  int done_count;
  int abort_count;

  int send_idle_pct;
  int stall_pct;
  bit hold_req;
  int cycle_count;
  int tick_count;

  // Opening ticks as {start_pressed, motor_busy}, run with delays 0, 1, 2, 3
  logic [1:0] opening_ticks [0:22] = '{
    2'b11, 2'b01, 2'b01, 2'b01, 2'b00, 2'b00, 2'b01, 2'b00, 2'b00, 2'b00,
    2'b00, 2'b00, 2'b00, 2'b00, 2'b01, 2'b00, 2'b00, 2'b10, 2'b00, 2'b00,
    2'b00, 2'b11, 2'b00
  };

  clamp_alignment_sequencer_unit #(
    .TIMER_WIDTH(TimerW)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  cas_tick_checker #(
    .TimerW(TimerW)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .done_count_o (done_count),
    .abort_count_o(abort_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Abort the run if it hangs
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: random stall, or a long hold each time the request toggles
  initial begin
    int hold_left;
    bit hold_seen;
    hold_left   = 0;
    hold_seen   = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req != hold_seen) begin
        hold_left = HoldCycles;
        hold_seen = hold_req;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Offer one tick beat after a random gap; return at the negedge after accept
  task automatic send_tick(in_beat_t tick);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= tick;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    tick_count++;
  endtask

  // Hold valid until the register write is taken; caller drops valid
  task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [DelayW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  // Drain, then load all four delays plus one write to an unused index
  task automatic apply_delays(logic [DelayW-1:0] pre_ext, logic [DelayW-1:0] hold,
                              logic [DelayW-1:0] after_ret, logic [DelayW-1:0] settle);
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (4) @(negedge clk_i);
    write_reg(RegPreExtend, pre_ext);
    write_reg(RegExtendHold, hold);
    write_reg(RegAfterRetract, after_ret);
    write_reg(RegClampSettle, settle);
    write_reg(CfgIndexW'($urandom_range(255, 4)), DelayW'($urandom));
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [DelayW-1:0] pick_delay(int style);
    case (style)
      DlyZero:  return '0;
      DlyMax:   return '1;
      DlyWide:  return DelayW'($urandom_range(40));
      DlyMixed: return ($urandom_range(3) == 0) ? '1 : DelayW'($urandom_range(6));
      default:  return DelayW'($urandom_range(6));
    endcase
  endfunction

  // Mostly clean ticks that let the sequence run, some fully random noise
  function automatic in_beat_t random_tick();
    in_beat_t tick;
    if ($urandom_range(99) < 8) begin
      tick = in_beat_t'(2'($urandom_range(3)));
    end else begin
      tick.start_pressed = 1'b0;
      tick.motor_busy    = ($urandom_range(2) != 0);
    end
    return tick;
  endfunction

  // Stimulus and verdict
  initial begin
    int delay_style [NumPhases];
    int phase_items;
    delay_style = '{DlyShort, DlyZero, DlyShort, DlyMax, DlyWide, DlyShort, DlyMixed,
                    DlyShort};
    tick_count    = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed walk: aborts, motor wait, zero and one tick dwells, done
    apply_delays(16'd0, 16'd1, 16'd2, 16'd3);
    foreach (opening_ticks[i]) send_tick(in_beat_t'(opening_ticks[i]));

    for (int p = 0; p < NumPhases; p++) begin
      apply_delays(pick_delay(delay_style[p]), pick_delay(delay_style[p]),
                   pick_delay(delay_style[p]), pick_delay(delay_style[p]));
      send_idle_pct = ((p % 4) == 1) ? 81 : ((p % 4) == 3) ? 28 : 0;
      stall_pct     = ((p % 4) == 2) ? 81 : ((p % 4) == 3) ? 28 : 0;
      phase_items   = (delay_style[p] == DlyMax) ? 40 : 86;
      for (int n = 0; n < phase_items; n++) begin
        // Back up the result side while ticks keep coming
        if (p == 0 && n == 30) hold_req = ~hold_req;
        // Pause the tick stream until the block has drained
        if (p == 5 && n == 40) begin
          in_valid_i <= 1'b0;
          wait (pending == 0);
          @(negedge clk_i);
        end
        send_tick(random_tick());
      end
    end
    in_valid_i <= 1'b0;

    wait (pending == 0);
    repeat (8) @(negedge clk_i);
    $display("Ran %0d ticks over %0d delay settings, from zero to full scale.",
             tick_count, NumPhases + 1);
    $display("Saw %0d completed sequences and %0d aborts.", done_count, abort_count);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
